// ===== sv/kmc_pkg.sv =====
package kmc_pkg;

	// Store and cluster sizing
	localparam int MAX_POINTS   = 64;
	localparam int NUM_CLUSTERS = 2;
	localparam int FRAC_BITS    = 10;
	localparam int COORD_W      = 16;
	localparam int ADDR_W       = $clog2(MAX_POINTS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int CL_W         = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
	localparam int IDX_W        = 3;
	localparam int ITER_W       = 8;

	// Arithmetic widths: coordinate sums, squared distances
	localparam int SUM_W  = COORD_W + ADDR_W;
	localparam int SQ_W   = 2 * COORD_W;
	localparam int DIST_W = SQ_W + 1;
	localparam int STEP_W = $clog2(SUM_W + 1);

	localparam logic [ITER_W-1:0] RESET_ITERATIONS = 8'd100;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	// Request to the shared divider
	typedef struct packed {
		logic start;
		sum_t dividend;
		cnt_t divisor;
	} div_req_t;

endpackage

// ===== sv/kmc_if.sv =====
interface kmc_point_if;
	logic             valid;
	logic             ready;
	kmc_pkg::coord_t  point_x;
	kmc_pkg::coord_t  point_y;
	logic             last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface kmc_cent_if;
	logic                       valid;
	logic                       ready;
	logic [kmc_pkg::IDX_W-1:0]  cluster_index;
	kmc_pkg::coord_t            centroid_x;
	kmc_pkg::coord_t            centroid_y;
	logic                       last_centroid;

	modport source (output valid, cluster_index, centroid_x, centroid_y, last_centroid,
		input ready);
	modport sink   (input valid, cluster_index, centroid_x, centroid_y, last_centroid,
		output ready);
endinterface

interface kmc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [kmc_pkg::ITER_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== sv/kmc_div.sv =====
module kmc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kmc_pkg::div_req_t req,
	output logic              done,
	output kmc_pkg::coord_t   quot
);
	import kmc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q;
	cnt_t              den_q;

	logic [CNT_W:0]    rem_shift;
	logic              qbit;
	logic [CNT_W:0]    rem_next;
	logic [SUM_W-1:0]  quot_full;

	// One restoring step per cycle
	always_comb begin
		rem_shift = {rem_q, mag_q[SUM_W-1]};
		qbit      = (rem_shift >= {1'b0, den_q});
		rem_next  = qbit ? (rem_shift - {1'b0, den_q}) : rem_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: magnitude shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			mag_q <= req.dividend[SUM_W-1] ? (SUM_W'(0) - req.dividend) : req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_W-2:0], qbit};
			rem_q <= rem_next[CNT_W-1:0];
		end
	end

	// Truncation toward zero: divide magnitudes, then restore the sign
	assign quot_full = neg_q ? (SUM_W'(0) - mag_q) : mag_q;
	assign quot      = quot_full[COORD_W-1:0];
	assign done      = done_q;

endmodule

// ===== sv/kmeans_2d_cluster_engine.sv =====
// 2-D k-means (Lloyd) clustering engine, signed Q5.10 coordinates.
// Channels: pt (sink) takes one point per transaction into a 64-entry point
// memory; a transaction with last_point set stores its point (if room) and
// starts a run. cent (source) then delivers one transaction per centroid in
// index order, last_centroid set on the final one. cfg (sink) writes the
// iteration count and is always ready; the user must write it only while
// idle, which the block does not enforce. Throughput: while loading, one
// point per cycle. After the last point, each pass streams the point memory
// once through a distance pipeline (read, square, compare/accumulate), then
// one shared serial divider computes the per-axis means at one quotient bit
// per cycle; an empty cluster skips its two divides.
// pt.ready is low from the last point until the final centroid is taken.
// Results sit in an output register; a stalled receiver holds the block
// in the emit phase with the result unchanged.
// Reset: iteration count returns to 100, the point count to zero, and the
// block waits for points. Point memory contents are not cleared.
module kmeans_2d_cluster_engine (
	input  logic clk,
	input  logic arst_n,
	kmc_point_if.sink  pt,
	kmc_cent_if.source cent,
	kmc_cfg_if.sink    cfg
);
	import kmc_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_ASSIGN,
		ST_DIV,
		ST_DIVWAIT,
		ST_NEXT,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [ITER_W-1:0]    iter_cfg_q;
	logic [ITER_W-1:0]    iter_q;
	cnt_t                 count_q;
	cnt_t                 issue_q;
	logic [CL_W:0]        sel_q;
	logic [CL_W-1:0]      emit_q;

	coord_t               cent_x_q [NUM_CLUSTERS];
	coord_t               cent_y_q [NUM_CLUSTERS];
	sum_t                 sum_x_q  [NUM_CLUSTERS];
	sum_t                 sum_y_q  [NUM_CLUSTERS];
	cnt_t                 mem_n_q  [NUM_CLUSTERS];

	logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
	logic [2*COORD_W-1:0] rd_data_s1;
	logic                 v_s1;
	logic                 v_s2;
	coord_t               px_s2;
	coord_t               py_s2;
	logic [SQ_W-1:0]      sqx_s2 [NUM_CLUSTERS];
	logic [SQ_W-1:0]      sqy_s2 [NUM_CLUSTERS];

	logic                 pt_acc;
	logic                 issue_en;
	logic [CL_W-1:0]      best;
	logic [CL_W-1:0]      div_cl;
	logic                 div_done;
	coord_t               div_quot;
	div_req_t             div_req;
	coord_t               px_s1;
	coord_t               py_s1;

	assign pt.ready  = (state_q == ST_LOAD);
	assign cfg.ready = 1'b1;
	assign pt_acc    = pt.valid && pt.ready;
	assign issue_en  = (state_q == ST_ASSIGN) && (issue_q < count_q);
	assign div_cl    = sel_q[CL_W:1];
	assign px_s1     = rd_data_s1[2*COORD_W-1:COORD_W];
	assign py_s1     = rd_data_s1[COORD_W-1:0];

	// Point memory: write while loading, registered read while assigning
	always_ff @(posedge clk) begin
		if (pt_acc && (count_q < cnt_t'(MAX_POINTS))) begin
			pt_mem[count_q[ADDR_W-1:0]] <= {pt.point_x, pt.point_y};
		end
		rd_data_s1 <= pt_mem[issue_q[ADDR_W-1:0]];
	end

	// Distance pipeline: squares of the per-axis offsets to each centroid
	always_ff @(posedge clk) begin
		logic signed [COORD_W:0]     dx;
		logic signed [COORD_W:0]     dy;
		logic signed [2*COORD_W+1:0] px2;
		logic signed [2*COORD_W+1:0] py2;
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		for (int c = 0; c < NUM_CLUSTERS; c++) begin
			dx  = (COORD_W+1)'(px_s1) - (COORD_W+1)'(cent_x_q[c]);
			dy  = (COORD_W+1)'(py_s1) - (COORD_W+1)'(cent_y_q[c]);
			px2 = dx * dx;
			py2 = dy * dy;
			sqx_s2[c] <= px2[SQ_W-1:0];
			sqy_s2[c] <= py2[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue_en;
			v_s2 <= v_s1;
		end
	end

	// Nearest centroid; strict compare keeps the lower index on a tie
	always_comb begin
		logic [DIST_W-1:0] d_best;
		logic [DIST_W-1:0] d;
		d_best = DIST_W'(sqx_s2[0]) + DIST_W'(sqy_s2[0]);
		best   = '0;
		for (int c = 1; c < NUM_CLUSTERS; c++) begin
			d = DIST_W'(sqx_s2[c]) + DIST_W'(sqy_s2[c]);
			if (d < d_best) begin
				d_best = d;
				best   = CL_W'(c);
			end
		end
	end

	// Divider request: sum of the selected axis over the cluster's count
	always_comb begin
		div_req.start    = (state_q == ST_DIV) && (mem_n_q[div_cl] != '0);
		div_req.dividend = sel_q[0] ? sum_y_q[div_cl] : sum_x_q[div_cl];
		div_req.divisor  = mem_n_q[div_cl];
	end

	kmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer, accumulators, centroids and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			iter_cfg_q    <= RESET_ITERATIONS;
			iter_q        <= '0;
			count_q       <= '0;
			issue_q       <= '0;
			sel_q         <= '0;
			emit_q        <= '0;
			cent.valid    <= 1'b0;
			cent.cluster_index <= '0;
			cent.centroid_x    <= '0;
			cent.centroid_y    <= '0;
			cent.last_centroid <= 1'b0;
			for (int c = 0; c < NUM_CLUSTERS; c++) begin
				cent_x_q[c] <= '0;
				cent_y_q[c] <= '0;
				sum_x_q[c]  <= '0;
				sum_y_q[c]  <= '0;
				mem_n_q[c]  <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				iter_cfg_q <= cfg.data;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (pt_acc) begin
						if (count_q < cnt_t'(MAX_POINTS)) begin
							count_q <= count_q + 1'b1;
						end
						if (pt.last_point) begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					for (int c = 0; c < NUM_CLUSTERS; c++) begin
						cent_x_q[c] <= COORD_W'(c << FRAC_BITS);
						cent_y_q[c] <= COORD_W'(c << FRAC_BITS);
						sum_x_q[c]  <= '0;
						sum_y_q[c]  <= '0;
						mem_n_q[c]  <= '0;
					end
					iter_q  <= '0;
					issue_q <= '0;
					if (iter_cfg_q == '0) begin
						emit_q             <= '0;
						cent.valid         <= 1'b1;
						cent.cluster_index <= '0;
						cent.centroid_x    <= '0;
						cent.centroid_y    <= '0;
						cent.last_centroid <= (NUM_CLUSTERS == 1);
						state_q            <= ST_EMIT;
					end else begin
						state_q <= ST_ASSIGN;
					end
				end
				ST_ASSIGN: begin
					if (issue_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (v_s2) begin
						sum_x_q[best] <= sum_x_q[best] + SUM_W'(px_s2);
						sum_y_q[best] <= sum_y_q[best] + SUM_W'(py_s2);
						mem_n_q[best] <= mem_n_q[best] + 1'b1;
					end
					if (!issue_en && !v_s1 && !v_s2) begin
						sel_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (mem_n_q[div_cl] != '0) begin
						state_q <= ST_DIVWAIT;
					end else if (sel_q == (CL_W+1)'(2 * NUM_CLUSTERS - 1)) begin
						state_q <= ST_NEXT;
					end else begin
						sel_q <= sel_q + 1'b1;
					end
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						if (sel_q[0]) begin
							cent_y_q[div_cl] <= div_quot;
						end else begin
							cent_x_q[div_cl] <= div_quot;
						end
						if (sel_q == (CL_W+1)'(2 * NUM_CLUSTERS - 1)) begin
							state_q <= ST_NEXT;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_NEXT: begin
					iter_q  <= iter_q + 1'b1;
					issue_q <= '0;
					for (int c = 0; c < NUM_CLUSTERS; c++) begin
						sum_x_q[c] <= '0;
						sum_y_q[c] <= '0;
						mem_n_q[c] <= '0;
					end
					if (iter_q + 1'b1 == iter_cfg_q) begin
						emit_q             <= '0;
						cent.valid         <= 1'b1;
						cent.cluster_index <= '0;
						cent.centroid_x    <= cent_x_q[0];
						cent.centroid_y    <= cent_y_q[0];
						cent.last_centroid <= (NUM_CLUSTERS == 1);
						state_q            <= ST_EMIT;
					end else begin
						state_q <= ST_ASSIGN;
					end
				end
				ST_EMIT: begin
					if (cent.valid && cent.ready) begin
						if (emit_q == CL_W'(NUM_CLUSTERS - 1)) begin
							cent.valid <= 1'b0;
							count_q    <= '0;
							state_q    <= ST_LOAD;
						end else begin
							emit_q             <= emit_q + 1'b1;
							cent.cluster_index <= IDX_W'(emit_q + 1'b1);
							cent.centroid_x    <= cent_x_q[emit_q + 1'b1];
							cent.centroid_y    <= cent_y_q[emit_q + 1'b1];
							cent.last_centroid <=
								(emit_q + 1'b1 == CL_W'(NUM_CLUSTERS - 1));
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import kmc_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int HOLD_CYCLES = 3000;

	typedef enum logic {ROW_CFG, ROW_PT} row_kind_e;

	// One row of the directed stimulus table
	typedef struct packed {
		row_kind_e           kind;
		logic [ITER_W-1:0]   iters;
		coord_t              x;
		coord_t              y;
		logic                last;
		logic                typed;
		coord_t              e0x;
		coord_t              e0y;
		coord_t              e1x;
		coord_t              e1y;
	} dir_row_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		coord_t            cx;
		coord_t            cy;
		logic              last;
	} centroid_t;

	logic clk;
	logic arst_n;

	kmc_point_if pt_if();
	kmc_cent_if  cent_if();
	kmc_cfg_if   cfg_if();

	kmeans_2d_cluster_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt_if),
		.cent   (cent_if),
		.cfg    (cfg_if)
	);

	// Predictor state: point store and iteration count
	coord_t            store_x[$];
	coord_t            store_y[$];
	logic [ITER_W-1:0] iter_setting;
	centroid_t         centroid_q[$];

	int  err_cnt;
	int  items_sent;
	int  hold_len;
	bit  calm;
	bit  row_typed;
	centroid_t typed_res[NUM_CLUSTERS];
	longint unsigned cycle_cnt = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Lloyd iterations over the stored points, results queued in index order
	function automatic void predict_centroids();
		longint cx[NUM_CLUSTERS];
		longint cy[NUM_CLUSTERS];
		int     grp[MAX_POINTS];
		longint dx, dy, d, best, sx, sy, n;
		centroid_t r;
		for (int c = 0; c < NUM_CLUSTERS; c++) begin
			cx[c] = longint'(c) << FRAC_BITS;
			cy[c] = longint'(c) << FRAC_BITS;
		end
		for (int it = 0; it < iter_setting; it++) begin
			for (int p = 0; p < store_x.size(); p++) begin
				grp[p] = 0;
				for (int c = 0; c < NUM_CLUSTERS; c++) begin
					dx = longint'(store_x[p]) - cx[c];
					dy = longint'(store_y[p]) - cy[c];
					d = dx * dx + dy * dy;
					if (c == 0 || d < best) begin
						best = d;
						grp[p] = c;
					end
				end
			end
			for (int c = 0; c < NUM_CLUSTERS; c++) begin
				sx = 0;
				sy = 0;
				n = 0;
				for (int p = 0; p < store_x.size(); p++) begin
					if (grp[p] == c) begin
						sx += store_x[p];
						sy += store_y[p];
						n++;
					end
				end
				// empty cluster keeps its centroid; division truncates toward zero
				if (n != 0) begin
					cx[c] = sx / n;
					cy[c] = sy / n;
				end
			end
		end
		for (int c = 0; c < NUM_CLUSTERS; c++) begin
			r.idx = IDX_W'(c);
			r.cx = coord_t'(cx[c]);
			r.cy = coord_t'(cy[c]);
			r.last = (c == NUM_CLUSTERS - 1);
			centroid_q.push_back(row_typed ? typed_res[c] : r);
		end
		store_x.delete();
		store_y.delete();
	endfunction

	// Point accepted by the block
	function automatic void take_point(coord_t x, coord_t y, logic last);
		if (store_x.size() < MAX_POINTS) begin
			store_x.push_back(x);
			store_y.push_back(y);
		end
		if (last)
			predict_centroids();
	endfunction

	// Send one point, with an occasional idle burst ahead of it
	task automatic send_point(coord_t x, coord_t y, logic last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			pt_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		pt_if.valid <= 1'b1;
		pt_if.point_x <= x;
		pt_if.point_y <= y;
		pt_if.last_point <= last;
		do @(posedge clk); while (!pt_if.ready);
		take_point(x, y, last);
		items_sent++;
	endtask

	task automatic wait_drained();
		while (centroid_q.size() != 0) @(posedge clk);
	endtask

	// Register write, only while the block is idle
	task automatic write_iters(logic [ITER_W-1:0] v);
		pt_if.valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		iter_setting = v;
	endtask

	// One point set: random or two blobs with random content
	task automatic send_set(int n);
		bit     blob;
		coord_t c0x, c0y, c1x, c1y, x, y;
		blob = 1'($urandom_range(0, 1));
		c0x = coord_t'($urandom);
		c0y = coord_t'($urandom);
		c1x = coord_t'($urandom);
		c1y = coord_t'($urandom);
		for (int i = 0; i < n; i++) begin
			if (blob && i[0]) begin
				x = c1x + coord_t'($urandom_range(0, 511)) - 16'sd256;
				y = c1y + coord_t'($urandom_range(0, 511)) - 16'sd256;
			end else if (blob) begin
				x = c0x + coord_t'($urandom_range(0, 511)) - 16'sd256;
				y = c0y + coord_t'($urandom_range(0, 511)) - 16'sd256;
			end else begin
				x = coord_t'($urandom);
				y = coord_t'($urandom);
			end
			send_point(x, y, i == n - 1);
		end
	endtask

	// Result side: random stalls, long hold-off on request, field checks
	initial begin
		centroid_t want;
		cent_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				cent_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				cent_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			cent_if.ready <= 1'b1;
			@(posedge clk);
			if (cent_if.valid && cent_if.ready) begin
				if (centroid_q.size() == 0) begin
					$error("centroid transaction with nothing expected");
					err_cnt++;
				end else begin
					want = centroid_q.pop_front();
					if (cent_if.cluster_index !== want.idx) begin
						$error("cluster_index: expected %0d, got %0d", want.idx,
							cent_if.cluster_index);
						err_cnt++;
					end
					if (cent_if.centroid_x !== want.cx) begin
						$error("centroid_x: expected %0d, got %0d", want.cx,
							cent_if.centroid_x);
						err_cnt++;
					end
					if (cent_if.centroid_y !== want.cy) begin
						$error("centroid_y: expected %0d, got %0d", want.cy,
							cent_if.centroid_y);
						err_cnt++;
					end
					if (cent_if.last_centroid !== want.last) begin
						$error("last_centroid: expected %0d, got %0d", want.last,
							cent_if.last_centroid);
						err_cnt++;
					end
				end
			end
		end
	end

	// Stimulus
	initial begin
		dir_row_t dir_rows[];
		int       n;
		arst_n = 1'b0;
		pt_if.valid = 1'b0;
		pt_if.point_x = '0;
		pt_if.point_y = '0;
		pt_if.last_point = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		iter_setting = RESET_ITERATIONS;
		err_cnt = 0;
		items_sent = 0;
		hold_len = 0;
		calm = 0;
		row_typed = 0;

		dir_rows = '{
			// single point at the origin, reset iteration count
			'{ROW_PT, 8'd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd1024, 16'sd1024},
			// zero iterations: initial centroids come back
			'{ROW_CFG, 8'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, 16'sh7fff, -16'sd32768, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, -16'sd32768, 16'sh7fff, 1'b1, 1'b1,
				16'sd0, 16'sd0, 16'sd1024, 16'sd1024},
			// coordinate extremes, one pass
			'{ROW_CFG, 8'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, -16'sd32768, -16'sd32768, 1'b1, 1'b1,
				-16'sd32768, -16'sd32768, 16'sh7fff, 16'sh7fff},
			// distance tie goes to the lower index; empty cluster keeps its place
			'{ROW_CFG, 8'd255, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, 16'sd512, 16'sd512, 1'b1, 1'b1,
				16'sd512, 16'sd512, 16'sd1024, 16'sd1024},
			// negative means truncate toward zero
			'{ROW_CFG, 8'd3, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, -16'sd3, -16'sd5, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, -16'sd4, -16'sd4, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, 16'sd2000, 16'sd2000, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			'{ROW_PT, 8'd0, 16'sd2001, 16'sd2003, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_iters(dir_rows[i].iters);
			end else begin
				row_typed = dir_rows[i].typed;
				typed_res[0] = '{3'd0, dir_rows[i].e0x, dir_rows[i].e0y, 1'b0};
				typed_res[1] = '{3'd1, dir_rows[i].e1x, dir_rows[i].e1y, 1'b1};
				send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last);
				row_typed = 0;
			end
		end

		// store overflow: points beyond the store are dropped
		write_iters(8'd2);
		send_set(MAX_POINTS + 3);

		// receiver holds off while points keep coming
		hold_len = HOLD_CYCLES;
		send_set(4);
		send_set(3);

		// sender waits for every result
		pt_if.valid <= 1'b0;
		wait_drained();

		while (items_sent < 550) begin
			if (items_sent > 500)
				calm = 1;
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_POINTS - 2, MAX_POINTS + 4)
				: $urandom_range(1, 12);
			if (n > 16)
				write_iters(ITER_W'($urandom_range(1, 4)));
			else if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0: write_iters(8'd0);
					1: write_iters(8'd255);
					2: write_iters(ITER_W'($urandom_range(20, 100)));
					default: write_iters(ITER_W'($urandom_range(1, 10)));
				endcase
			end else if (iter_setting > 20 && n > 8)
				n = 8;
			send_set(n);
		end

		pt_if.valid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/kmc_pkg.sv
sv/kmc_if.sv
sv/kmc_div.sv
sv/kmeans_2d_cluster_engine.sv
tb/tb.sv
